>>> src/sfdc_pkg.sv
// shared types, constants and plane tables for the sphere frustum distance cull block
package sfdc_pkg;

  localparam int unsigned PLANE_COUNT = 6;
  localparam int unsigned MAT_SLOTS   = 16;
  localparam int unsigned CAM_AXES    = 3;
  localparam int unsigned COEF_COUNT  = PLANE_COUNT * 4;

  localparam logic [30:0] CULL_RESET   = 31'd6553600;
  localparam logic [3:0]  SLOT_LAST    = 4'd15;
  localparam logic [2:0]  PLANE_LAST   = 3'd5;
  localparam logic        REG_CULL_IDX = 1'b0;

  typedef enum logic [1:0] {
    KIND_MAT    = 2'd0,
    KIND_CAM    = 2'd1,
    KIND_SPHERE = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    CAUSE_ALWAYS  = 2'd0,
    CAUSE_PASS    = 2'd1,
    CAUSE_OUTSIDE = 2'd2,
    CAUSE_FAR     = 2'd3
  } cause_e;

  typedef enum logic [1:0] {
    MODE_ADD,
    MODE_SUB,
    MODE_COPY
  } mode_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DRV_W,
    ST_DRV_E,
    ST_DRV_SQ,
    ST_DRV_ACC,
    ST_SQRT_GO,
    ST_SQRT_WAIT,
    ST_NRM_RD,
    ST_NRM_WAIT,
    ST_TST_INIT,
    ST_TST_MUL,
    ST_TST_ACC,
    ST_DST_MUL,
    ST_DST_ACC,
    ST_LIM_MUL,
    ST_LIM_CHK,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic start;
    logic sqrt_mode;
  } iter_req_t;

  // matrix column combined with column 4 for each plane
  function automatic logic [1:0] plane_col(input logic [2:0] p);
    logic [1:0] c;
    case (p)
      3'd0, 3'd1: c = 2'd0;
      3'd2, 3'd3: c = 2'd1;
      default:    c = 2'd2;
    endcase
    return c;
  endfunction

  function automatic mode_e plane_mode(input logic [2:0] p);
    mode_e m;
    case (p)
      3'd0, 3'd3: m = MODE_ADD;
      3'd4:       m = MODE_COPY;
      default:    m = MODE_SUB;
    endcase
    return m;
  endfunction

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

>>> src/sfdc_mul.sv
// shared signed 33x33 multiplier with registered product
module sfdc_mul (
  input  logic               clk_i,
  input  logic signed [32:0] a_i,
  input  logic signed [32:0] b_i,
  output logic signed [65:0] p_o
);

  logic signed [65:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

>>> src/sfdc_iter.sv
// shift-subtract unit shared by square root (2 bits a step) and division (1 bit a step)
module sfdc_iter (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sfdc_pkg::iter_req_t req_i,
  input  logic [63:0]         src_i,
  input  logic [31:0]         dvs_i,
  output logic                done_o,
  output logic [47:0]         res_o
);
  import sfdc_pkg::*;

  localparam logic [5:0] SqrtSteps = 6'd32;
  localparam logic [5:0] DivSteps  = 6'd48;

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        mode_q;
  logic [63:0] src_q;
  logic [34:0] rem_q;
  logic [47:0] res_q;
  logic [31:0] dvs_q;
  logic [34:0] sh, trial, diff;
  logic        ge;

  always_comb begin
    sh    = mode_q ? {rem_q[32:0], src_q[63:62]} : {rem_q[33:0], src_q[63]};
    trial = mode_q ? {1'b0, res_q[31:0], 2'b01} : {3'b000, dvs_q};
    ge    = (sh >= trial);
    diff  = sh - trial;
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.sqrt_mode ? SqrtSteps : DivSteps;
    end else if (busy_q) begin
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      mode_q <= req_i.sqrt_mode;
      src_q  <= src_i;
      dvs_q  <= dvs_i;
      rem_q  <= '0;
      res_q  <= '0;
    end else if (busy_q) begin
      src_q <= mode_q ? {src_q[61:0], 2'b00} : {src_q[62:0], 1'b0};
      rem_q <= ge ? diff : sh;
      res_q <= {res_q[46:0], ge};
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

>>> src/sphere_frustum_distance_cull_core.sv
// top level: sphere frustum and distance culling with shared multiplier and sqrt/divide unit
//
// input channel (in_valid_i / in_ready_o) carries one transaction per load or sphere.
// kind 0 writes a matrix entry, kind 1 a camera axis; both give no result. a matrix
// load to slot 15 starts plane derivation for all six planes: per plane the row sums
// and squares, the square root on the shared unit and a division per coefficient
// unless the length is zero; in_ready_o stays low meanwhile.
// kind 2 tests a sphere: plane by plane through the single multiplier, then the distance
// check; an object outside an early plane or flagged always-draw finishes sooner.
// the result sits in an output register (out_valid_o / out_ready_i); while it is
// stalled the block still takes loads and starts the next sphere, holding that
// result in its final state until the register frees up.
// the APB port writes and reads cull_distance at addresses 0 to 3; pready is always high.
// reset clears the sequencer and out_valid_o, and sets cull_distance to 100.0;
// matrix, camera and plane storage is undefined until loaded.
module sphere_frustum_distance_cull_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         kind_i,
  input  logic [3:0]         slot_i,
  input  logic signed [31:0] load_value_i,
  input  logic signed [31:0] center_x_i,
  input  logic signed [31:0] center_y_i,
  input  logic signed [31:0] center_z_i,
  input  logic [30:0]        radius_i,
  input  logic               always_draw_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               visible_o,
  output logic [1:0]         cause_o
);
  import sfdc_pkg::*;

  state_e             state_q, state_d;
  logic [2:0]         p_q, p_d;
  logic [1:0]         k_q, k_d;
  logic signed [66:0] acc_q, acc_d;
  logic signed [31:0] w_q, w_d, cur_q, cur_d;
  logic [31:0]        len_q, len_d;
  cause_e             cause_q, cause_d;
  logic               out_valid_q, out_vis_q, out_load;
  cause_e             out_cause_q;
  logic [30:0]        cull_q, rad_q;

  logic signed [31:0] mat_q [MAT_SLOTS];
  logic signed [31:0] cam_q [CAM_AXES];
  logic signed [31:0] cen_q [CAM_AXES];
  logic signed [31:0] pl_q  [COEF_COUNT];

  logic [3:0]         mat_ra;
  logic signed [31:0] mat_rd;
  logic [4:0]         pl_ra, pl_wa;
  logic signed [31:0] pl_rd, pl_wd;
  logic               pl_we;
  logic               in_acc, cfg_we;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  iter_req_t          it_req;
  logic [63:0]        it_src;
  logic               it_done;
  logic [47:0]        it_res;

  logic signed [32:0] de_v, dd, dd_neg, t_sum;
  logic signed [31:0] sel_cen, sel_cam;
  logic [31:0]        dd_mag, lim, rd_mag;
  logic signed [66:0] acc_sum;
  mode_e              mode;

  assign pready     = 1'b1;
  assign cfg_we     = psel & penable & pwrite & (paddr[2] == REG_CULL_IDX);
  assign prdata     = (paddr[2] == REG_CULL_IDX) ? {1'b0, cull_q} : '0;
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i & in_ready_o;

  assign mat_rd  = mat_q[mat_ra];
  assign pl_rd   = pl_q[pl_ra];
  assign sel_cen = cen_q[k_q];
  assign sel_cam = cam_q[k_q];

  always_comb begin
    mode    = plane_mode(p_q);
    dd      = {sel_cen[31], sel_cen} - {sel_cam[31], sel_cam};
    dd_neg  = -dd;
    dd_mag  = dd[32] ? dd_neg[31:0] : dd[31:0];
    lim     = {1'b0, cull_q} + {1'b0, rad_q};
    rd_mag  = pl_rd[31] ? (~pl_rd + 32'd1) : pl_rd;
    t_sum   = {pl_rd[31], pl_rd} + {2'b00, rad_q};
    acc_sum = acc_q + {mul_p[65], mul_p};
    case (mode)
      MODE_ADD: de_v = {w_q[31], w_q} + {mat_rd[31], mat_rd};
      MODE_SUB: de_v = {w_q[31], w_q} - {mat_rd[31], mat_rd};
      default:  de_v = {mat_rd[31], mat_rd};
    endcase
  end

  always_comb begin
    state_d  = state_q;
    p_d      = p_q;
    k_d      = k_q;
    acc_d    = acc_q;
    w_d      = w_q;
    cur_d    = cur_q;
    len_d    = len_q;
    cause_d  = cause_q;
    mat_ra   = {k_q, 2'b11};
    pl_ra    = {p_q, k_q};
    pl_wa    = {p_q, k_q};
    pl_wd    = '0;
    pl_we    = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    it_req   = '0;
    it_src   = {rd_mag, 32'h0};
    out_load = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          p_d = '0;
          k_d = '0;
          case (kind_i)
            KIND_MAT: begin
              if (slot_i == SLOT_LAST) state_d = ST_DRV_W;
            end
            KIND_SPHERE: begin
              if (always_draw_i) begin
                cause_d = CAUSE_ALWAYS;
                state_d = ST_RESULT;
              end else begin
                state_d = ST_TST_INIT;
              end
            end
            default: ;
          endcase
        end
      end
      ST_DRV_W: begin
        w_d = mat_rd;
        if (k_q == 2'd0) acc_d = '0;
        state_d = ST_DRV_E;
      end
      ST_DRV_E: begin
        mat_ra = {k_q, plane_col(p_q)};
        pl_we  = 1'b1;
        pl_wd  = sat33(de_v);
        cur_d  = sat33(de_v);
        state_d = (k_q == 2'd3) ? ST_SQRT_GO : ST_DRV_SQ;
      end
      ST_DRV_SQ: begin
        mul_a   = {cur_q[31], cur_q};
        mul_b   = {cur_q[31], cur_q};
        state_d = ST_DRV_ACC;
      end
      ST_DRV_ACC: begin
        acc_d   = acc_sum;
        k_d     = k_q + 2'd1;
        state_d = ST_DRV_W;
      end
      ST_SQRT_GO: begin
        it_req.start     = 1'b1;
        it_req.sqrt_mode = 1'b1;
        it_src           = acc_q[63:0];
        state_d          = ST_SQRT_WAIT;
      end
      ST_SQRT_WAIT: begin
        if (it_done) begin
          len_d = it_res[31:0];
          k_d   = '0;
          if (it_res[31:0] != 32'd0) begin
            state_d = ST_NRM_RD;
          end else if (p_q == PLANE_LAST) begin
            state_d = ST_IDLE;
          end else begin
            p_d     = p_q + 3'd1;
            state_d = ST_DRV_W;
          end
        end
      end
      ST_NRM_RD: begin
        it_req.start = 1'b1;
        cur_d        = pl_rd;
        state_d      = ST_NRM_WAIT;
      end
      ST_NRM_WAIT: begin
        if (it_done) begin
          pl_we = 1'b1;
          if (cur_q[31]) begin
            pl_wd = (it_res > 48'd2147483648) ? 32'sh8000_0000 : -it_res[31:0];
          end else begin
            pl_wd = (it_res > 48'd2147483647) ? 32'sh7fff_ffff : it_res[31:0];
          end
          if (k_q != 2'd3) begin
            k_d     = k_q + 2'd1;
            state_d = ST_NRM_RD;
          end else if (p_q == PLANE_LAST) begin
            state_d = ST_IDLE;
          end else begin
            p_d     = p_q + 3'd1;
            k_d     = '0;
            state_d = ST_DRV_W;
          end
        end
      end
      ST_TST_INIT: begin
        pl_ra   = {p_q, 2'd3};
        acc_d   = {{18{t_sum[32]}}, t_sum, 16'h0};
        k_d     = '0;
        state_d = ST_TST_MUL;
      end
      ST_TST_MUL: begin
        mul_a   = {pl_rd[31], pl_rd};
        mul_b   = {sel_cen[31], sel_cen};
        state_d = ST_TST_ACC;
      end
      ST_TST_ACC: begin
        acc_d = acc_sum;
        if (k_q != 2'd2) begin
          k_d     = k_q + 2'd1;
          state_d = ST_TST_MUL;
        end else if (acc_sum[66]) begin
          cause_d = CAUSE_OUTSIDE;
          state_d = ST_RESULT;
        end else if (p_q == PLANE_LAST) begin
          acc_d   = '0;
          k_d     = '0;
          state_d = ST_DST_MUL;
        end else begin
          p_d     = p_q + 3'd1;
          state_d = ST_TST_INIT;
        end
      end
      ST_DST_MUL: begin
        mul_a   = {1'b0, dd_mag};
        mul_b   = {1'b0, dd_mag};
        state_d = ST_DST_ACC;
      end
      ST_DST_ACC: begin
        acc_d = acc_sum;
        if (k_q == 2'd2) begin
          state_d = ST_LIM_MUL;
        end else begin
          k_d     = k_q + 2'd1;
          state_d = ST_DST_MUL;
        end
      end
      ST_LIM_MUL: begin
        mul_a   = {1'b0, lim};
        mul_b   = {1'b0, lim};
        state_d = ST_LIM_CHK;
      end
      ST_LIM_CHK: begin
        // distance sum wider than 64 bits always counts as too far
        if ((acc_q[66:64] != 3'd0) || (acc_q[63:0] > mul_p[63:0])) begin
          cause_d = CAUSE_FAR;
        end else begin
          cause_d = CAUSE_PASS;
        end
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      p_q         <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      cull_q      <= CULL_RESET;
    end else begin
      state_q <= state_d;
      p_q     <= p_d;
      k_q     <= k_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we) cull_q <= pwdata[30:0];
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    w_q     <= w_d;
    cur_q   <= cur_d;
    len_q   <= len_d;
    cause_q <= cause_d;
    if (out_load) begin
      out_vis_q   <= (cause_q == CAUSE_ALWAYS) || (cause_q == CAUSE_PASS);
      out_cause_q <= cause_q;
    end
    if (in_acc) begin
      cen_q[0] <= center_x_i;
      cen_q[1] <= center_y_i;
      cen_q[2] <= center_z_i;
      rad_q    <= radius_i;
    end
    if (in_acc && (kind_i == KIND_MAT)) mat_q[slot_i] <= load_value_i;
    if (in_acc && (kind_i == KIND_CAM) && (slot_i < 4'(CAM_AXES))) begin
      cam_q[slot_i[1:0]] <= load_value_i;
    end
    if (pl_we) pl_q[pl_wa] <= pl_wd;
  end

  sfdc_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  sfdc_iter u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (it_req),
    .src_i  (it_src),
    .dvs_i  (len_q),
    .done_o (it_done),
    .res_o  (it_res)
  );

  assign out_valid_o = out_valid_q;
  assign visible_o   = out_vis_q;
  assign cause_o     = out_cause_q;

endmodule

>>> src/sfdc_checker.sv
// port-level checks for the cull core, bound to the top level
module sfdc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [1:0] kind_i,
  input logic [3:0] slot_i,
  input logic       always_draw_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       visible_o,
  input logic [1:0] cause_o
);
  import sfdc_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i & in_ready_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(visible_o) && $stable(cause_o))
    else $error("result changed while stalled");

  a_vis_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (visible_o == ((cause_o == CAUSE_ALWAYS) || (cause_o == CAUSE_PASS))))
    else $error("visible disagrees with cause");

  a_load_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (kind_i != KIND_SPHERE) && !((kind_i == KIND_MAT) && (slot_i == SLOT_LAST))
    |=> in_ready_o)
    else $error("plain load did not complete in one cycle");

  a_sphere_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (kind_i == KIND_SPHERE) |=> !in_ready_o)
    else $error("ready while a sphere is in work");

  a_always_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (kind_i == KIND_SPHERE) && always_draw_i && !out_valid_o
    |-> ##2 (out_valid_o && (cause_o == CAUSE_ALWAYS)))
    else $error("always-draw result missing");

endmodule

bind sphere_frustum_distance_cull_core sfdc_checker u_sfdc_checker (.*);

>>> verif/sfdc_cull_checker.sv
// cull core checker: predicts sphere verdicts, checks accepted results and readback
`timescale 1ns / 100ps

module sfdc_cull_checker
  import sfdc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic [31:0]        prdata,
  input  logic               pready,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [1:0]         kind_i,
  input  logic [3:0]         slot_i,
  input  logic signed [31:0] load_value_i,
  input  logic signed [31:0] center_x_i,
  input  logic signed [31:0] center_y_i,
  input  logic signed [31:0] center_z_i,
  input  logic [30:0]        radius_i,
  input  logic               always_draw_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic               visible_i,
  input  logic [1:0]         cause_i,
  output int                 fail_count_o,
  output int                 verdicts_pending_o,
  output int                 cause_seen_o [4]
);

  localparam logic [2:0] CULL_ADDR = 3'd0;

  typedef struct packed {
    logic   visible;
    cause_e cause;
  } verdict_t;

  verdict_t           verdict_q[$];
  logic [30:0]        draw_dist;
  logic signed [31:0] mat_m [16];
  logic signed [31:0] cam_m [3];
  logic signed [31:0] plane_m [24];

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fff_ffff;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // left, right, top, bottom, near, far from column 4 and columns 1..3
  task automatic derive_planes();
    int col, mode;
    longint w, e, v, c;
    longint unsigned acc, len;
    for (int p = 0; p < 6; p++) begin
      col  = p / 2;
      mode = (p == 0 || p == 3) ? 1 : (p == 4) ? 0 : -1;
      for (int k = 0; k < 4; k++) begin
        w = mat_m[k*4+3];
        e = mat_m[k*4+col];
        v = (mode > 0) ? w + e : (mode < 0) ? w - e : e;
        plane_m[p*4+k] = clamp32(v);
      end
      acc = 0;
      for (int k = 0; k < 3; k++) begin
        c   = plane_m[p*4+k];
        acc = acc + longint'(c * c);
      end
      len = int_sqrt(acc);
      if (len != 0) begin
        for (int k = 0; k < 4; k++) begin
          v = longint'(plane_m[p*4+k]) * 65536;
          plane_m[p*4+k] = clamp32(v / longint'(len));
        end
      end
    end
  endtask

  function automatic cause_e predict_cause(input logic signed [31:0] cx,
      input logic signed [31:0] cy, input logic signed [31:0] cz,
      input logic [30:0] r, input logic always_draw);
    longint d, dd, rr;
    longint unsigned m, lim, thresh;
    logic [65:0] dist_sum;
    logic signed [31:0] ctr [3];
    if (always_draw) return CAUSE_ALWAYS;
    ctr[0] = cx;
    ctr[1] = cy;
    ctr[2] = cz;
    rr = longint'({33'd0, r});
    for (int p = 0; p < 6; p++) begin
      d = longint'(plane_m[p*4+3]) * 65536 + rr * 65536;
      for (int k = 0; k < 3; k++) d = d + longint'(plane_m[p*4+k]) * longint'(ctr[k]);
      if (d < 0) return CAUSE_OUTSIDE;
    end
    lim      = longint'({33'd0, draw_dist}) + longint'(rr);
    thresh   = lim * lim;
    dist_sum = '0;
    for (int k = 0; k < 3; k++) begin
      dd       = longint'(ctr[k]) - longint'(cam_m[k]);
      m        = (dd < 0) ? -dd : dd;
      dist_sum = dist_sum + {2'b00, m * m};
    end
    if ((dist_sum[65:64] != 2'b00) || dist_sum[63:0] > thresh) return CAUSE_FAR;
    return CAUSE_PASS;
  endfunction

  initial begin
    draw_dist    = CULL_RESET;
    fail_count_o = 0;
    foreach (cause_seen_o[i]) cause_seen_o[i] = 0;
    foreach (mat_m[i]) mat_m[i] = '0;
    foreach (cam_m[i]) cam_m[i] = '0;
    foreach (plane_m[i]) plane_m[i] = '0;
  end

  assign verdicts_pending_o = verdict_q.size();

  always @(posedge clk_i) begin
    verdict_t exp_v;
    cause_e   cz;
    if (rst_ni) begin
      if (psel && penable && pready && paddr == CULL_ADDR) begin
        if (pwrite) begin
          draw_dist = pwdata[30:0];
        end else if (prdata != {1'b0, draw_dist}) begin
          $error("cull_distance readback: expected %0d, actual %0d", draw_dist, prdata);
          fail_count_o++;
        end
      end

      if (in_valid_i && in_ready_i) begin
        case (kind_i)
          KIND_MAT: begin
            mat_m[slot_i] = load_value_i;
            if (slot_i == SLOT_LAST) derive_planes();
          end
          KIND_CAM: begin
            if (slot_i < CAM_AXES) cam_m[slot_i] = load_value_i;
          end
          KIND_SPHERE: begin
            cz = predict_cause(center_x_i, center_y_i, center_z_i, radius_i, always_draw_i);
            exp_v.cause   = cz;
            exp_v.visible = (cz == CAUSE_ALWAYS || cz == CAUSE_PASS);
            verdict_q = {verdict_q, exp_v};
          end
          default: ;
        endcase
      end

      if (out_valid_i && out_ready_i) begin
        if (verdict_q.size() == 0) begin
          $error("result transaction with no sphere pending");
          fail_count_o++;
        end else begin
          exp_v = verdict_q.pop_front();
          cause_seen_o[cause_i]++;
          if (visible_i !== exp_v.visible) begin
            $error("visible: expected %0d, actual %0d", exp_v.visible, visible_i);
            fail_count_o++;
          end
          if (cause_i !== exp_v.cause) begin
            $error("cause: expected %0d, actual %0d", exp_v.cause, cause_i);
            fail_count_o++;
          end
        end
      end
    end
  end

endmodule

>>> verif/tb.sv
// testbench top: stimulus, configuration writes and verdict for the cull core
`timescale 1ns / 100ps

module tb;
  import sfdc_pkg::*;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int SETTLE       = 2000;
  localparam int HOLD_LEN     = 300;

  logic               clk, rst_n;
  logic               psel, penable, pwrite, pready;
  logic [2:0]         paddr;
  logic [31:0]        pwdata, prdata;
  logic               in_valid, in_ready;
  logic [1:0]         kind;
  logic [3:0]         slot;
  logic signed [31:0] load_value, cx, cy, cz;
  logic [30:0]        radius;
  logic               always_draw;
  logic               out_valid, out_ready, visible;
  logic [1:0]         cause;

  int fail_count, pending;
  int cause_seen [4];
  int cycles, items_sent;
  int tx_idle_pct, rx_idle_pct;
  int hold_reqs, hold_done, hold_left;

  sphere_frustum_distance_cull_core dut (
    .clk_i(clk), .rst_ni(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .kind_i(kind), .slot_i(slot), .load_value_i(load_value),
    .center_x_i(cx), .center_y_i(cy), .center_z_i(cz),
    .radius_i(radius), .always_draw_i(always_draw),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .visible_o(visible), .cause_o(cause)
  );

  sfdc_cull_checker chk (
    .clk_i(clk), .rst_ni(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .kind_i(kind), .slot_i(slot), .load_value_i(load_value),
    .center_x_i(cx), .center_y_i(cy), .center_z_i(cz),
    .radius_i(radius), .always_draw_i(always_draw),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .visible_i(visible), .cause_i(cause),
    .fail_count_o(fail_count), .verdicts_pending_o(pending),
    .cause_seen_o(cause_seen)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // receiver: random stalls plus a long hold-off whenever the stimulus requests one
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_reqs != hold_done) begin
      hold_done <= hold_done + 1;
      hold_left <= HOLD_LEN;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic send_item(input kind_e k, input logic [3:0] s, input logic [31:0] lv,
      input logic [31:0] x, input logic [31:0] y, input logic [31:0] z,
      input logic [30:0] r, input logic ad);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    kind        <= k;
    slot        <= s;
    load_value  <= lv;
    cx          <= x;
    cy          <= y;
    cz          <= z;
    radius      <= r;
    always_draw <= ad;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_load(input kind_e k, input logic [3:0] s, input logic [31:0] lv);
    send_item(k, s, lv, $urandom, $urandom, $urandom, 31'($urandom),
              1'($urandom_range(1)));
  endtask

  task automatic send_sphere(input logic [31:0] x, input logic [31:0] y,
      input logic [31:0] z, input logic [30:0] r, input logic ad);
    send_item(KIND_SPHERE, 4'($urandom), $urandom, x, y, z, r, ad);
  endtask

  function automatic logic [31:0] rand_coord();
    if ($urandom_range(99) < 85) return $urandom_range(0, 128 * 65536) - 64 * 65536;
    return $urandom;
  endfunction

  function automatic logic [30:0] rand_radius();
    if ($urandom_range(99) < 80) return 31'($urandom_range(0, 16 * 65536));
    return 31'($urandom);
  endfunction

  function automatic logic [31:0] rand_entry();
    if ($urandom_range(99) < 90) return $urandom_range(0, 4 * 65536) - 2 * 65536;
    return $urandom;
  endfunction

  task automatic apb_access(input logic wr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= 3'd0;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_draw_dist(input logic [30:0] d);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    apb_access(1'b1, {1'b0, d});
    apb_access(1'b0, '0);
  endtask

  task automatic load_frame();
    for (int i = 0; i < 16; i++) send_load(KIND_MAT, i[3:0], rand_entry());
    for (int i = 0; i < 3; i++) send_load(KIND_CAM, i[3:0], rand_coord());
  endtask

  task automatic random_phase(input int n);
    int stop, sel;
    stop = items_sent + n;
    while (items_sent < stop) begin
      sel = $urandom_range(99);
      if (sel < 3) load_frame();
      else if (sel < 9) send_load(KIND_MAT, 4'($urandom), rand_entry());
      else if (sel < 15) send_load(KIND_CAM, 4'($urandom), rand_coord());
      else if (sel < 17) send_item(kind_e'(2'd3), 4'($urandom), $urandom, $urandom,
                                   $urandom, $urandom, 31'($urandom),
                                   1'($urandom_range(1)));
      else send_sphere(rand_coord(), rand_coord(), rand_coord(), rand_radius(),
                       $urandom_range(99) < 10);
    end
  endtask

  initial begin
    rst_n       <= 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    in_valid    <= 1'b0;
    kind        <= KIND_SPHERE;
    slot        <= '0;
    load_value  <= '0;
    cx          <= '0;
    cy          <= '0;
    cz          <= '0;
    radius      <= '0;
    always_draw <= 1'b0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_reqs   = 0;
    hold_done   <= 0;
    hold_left   <= 0;
    items_sent  = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // degenerate matrix: every plane normal is zero, near plane is all zero
    for (int i = 0; i < 15; i++) send_load(KIND_MAT, i[3:0], 32'd0);
    send_load(KIND_MAT, SLOT_LAST, 32'd65536);
    send_load(KIND_CAM, 4'd0, 32'd0);
    send_load(KIND_CAM, 4'd1, 32'd0);
    send_load(KIND_CAM, 4'd2, 32'd0);
    send_load(KIND_CAM, 4'd7, 32'h7fff_ffff);
    send_sphere(32'd0, 32'd0, 32'd0, 31'd0, 1'b0);
    send_sphere(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 31'h7fff_ffff, 1'b0);
    send_sphere(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'd0, 1'b1);
    send_sphere(32'd200 << 16, 32'd0, 32'd0, 31'd0, 1'b0);
    send_item(kind_e'(2'd3), 4'hf, 32'hffff_ffff, '1, '1, '1, '1, 1'b1);
    // identity-like matrix gives a box-shaped frustum
    for (int i = 0; i < 16; i++)
      send_load(KIND_MAT, i[3:0], (i % 5 == 0) ? 32'd65536 : 32'd0);
    send_sphere(32'd10 << 16, 32'd0, 32'd0, 31'd0, 1'b0);
    send_sphere(32'd10 << 16, 32'd0, 32'd0, 31'd9 << 16, 1'b0);
    send_sphere(32'd0, 32'd0, 32'hfffe_0000, 31'd65536, 1'b0);
    // saturating row sums
    for (int i = 0; i < 16; i++)
      send_load(KIND_MAT, i[3:0], (i % 2 == 0) ? 32'h7fff_ffff : 32'h8000_0000);
    send_sphere(32'h7fff_ffff, 32'd0, 32'h8000_0000, 31'h7fff_ffff, 1'b0);
    send_sphere(32'd0, 32'd0, 32'd0, 31'd0, 1'b0);
    load_frame();

    set_draw_dist(31'h7fff_ffff);
    tx_idle_pct = 12;
    rx_idle_pct = 78;
    random_phase(130);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    random_phase(130);

    set_draw_dist(31'd0);
    tx_idle_pct = 78;
    rx_idle_pct = 12;
    random_phase(260);

    set_draw_dist(31'($urandom_range(0, 200 * 65536)));
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_reqs = hold_reqs + 1;
    for (int i = 0; i < 12; i++)
      send_sphere(rand_coord(), rand_coord(), rand_coord(), rand_radius(), 1'b0);
    random_phase(250);
    send_sphere(32'd0, 32'd0, 32'd0, 31'd0, 1'b1);
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("tb: %0d input transactions, results always/pass/outside/far = %0d/%0d/%0d/%0d",
             items_sent, cause_seen[0], cause_seen[1], cause_seen[2], cause_seen[3]);
    $display("tb: draw distances max, zero, random; matrix reloads, stalls and hold-off");
    if (fail_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
